>>> hw/rtl/tun_pkg.sv
// Package for the triangle unit normal block: default sizes and lane count.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tun_pkg;
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int LANES                = 3;
    localparam int VERTEX_FIELDS        = 9;
endpackage
`default_nettype wire

>>> hw/rtl/tun_cross.sv
// Front end of the normal pipeline: edges, cross product and squared components.
// Four register stages advanced by a common enable; depends on tun_pkg.
`default_nettype none
module tun_cross
    import tun_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic signed [CW-1:0] pt [VERTEX_FIELDS],
    output logic        [4*CW+1:0]   sq [LANES],
    output logic                     neg [LANES],
    output logic                     degen
);
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int MW = 2 * CW + 1;

    logic signed [DW-1:0] d_reg [6];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [PW-1:0] c_reg [LANES];
    logic        [2*MW-1:0] sq_reg [LANES];
    logic                 neg_reg [LANES];
    logic                 degen_reg;
    logic        [MW-1:0] mag [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mag[i] = c_reg[i][PW-1] ? MW'(-c_reg[i]) : MW'(c_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                d_reg[i]     <= DW'(pt[i]) - DW'(pt[i+3]);
                d_reg[i+3]   <= DW'(pt[i]) - DW'(pt[i+6]);
            end
            prod_reg[0] <= PW'(d_reg[1]) * PW'(d_reg[5]);
            prod_reg[1] <= PW'(d_reg[2]) * PW'(d_reg[4]);
            prod_reg[2] <= PW'(d_reg[2]) * PW'(d_reg[3]);
            prod_reg[3] <= PW'(d_reg[0]) * PW'(d_reg[5]);
            prod_reg[4] <= PW'(d_reg[0]) * PW'(d_reg[4]);
            prod_reg[5] <= PW'(d_reg[1]) * PW'(d_reg[3]);
            for (int i = 0; i < LANES; i++)
            begin
                c_reg[i]   <= prod_reg[2*i] - prod_reg[2*i+1];
                sq_reg[i]  <= (2*MW)'(mag[i]) * (2*MW)'(mag[i]);
                neg_reg[i] <= c_reg[i][PW-1];
            end
            degen_reg <= (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
        end
    end

    assign sq    = sq_reg;
    assign neg   = neg_reg;
    assign degen = degen_reg;
endmodule
`default_nettype wire

>>> hw/rtl/tun_cell.sv
// One cell of the quotient chain: settles one bit of the scaled ratio per lane.
// Holds residual, running product and partial quotient; depends on tun_pkg.
`default_nettype none
module tun_cell
    import tun_pkg::*;
#(
    parameter int AW = 102,
    parameter int KW = 16,
    parameter int J  = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [AW-1:0] r_in [LANES],
    input  wire logic [AW-1:0] ks_in [LANES],
    input  wire logic [KW-1:0] k_in [LANES],
    input  wire logic          neg_in [LANES],
    input  wire logic [AW-1:0] s_in,
    input  wire logic          degen_in,
    output logic      [AW-1:0] r_out [LANES],
    output logic      [AW-1:0] ks_out [LANES],
    output logic      [KW-1:0] k_out [LANES],
    output logic               neg_out [LANES],
    output logic      [AW-1:0] s_out,
    output logic               degen_out
);
    logic [AW-1:0] r_reg [LANES];
    logic [AW-1:0] ks_reg [LANES];
    logic [KW-1:0] k_reg [LANES];
    logic          neg_reg [LANES];
    logic [AW-1:0] s_reg;
    logic          degen_reg;
    logic [AW-1:0] trial [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = (ks_in[i] << (J + 1)) + (s_in << (2 * J));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (r_in[i] >= trial[i])
                begin
                    r_reg[i]  <= r_in[i] - trial[i];
                    ks_reg[i] <= ks_in[i] + (s_in << J);
                    k_reg[i]  <= k_in[i] | (KW'(1) << J);
                end
                else
                begin
                    r_reg[i]  <= r_in[i];
                    ks_reg[i] <= ks_in[i];
                    k_reg[i]  <= k_in[i];
                end
                neg_reg[i] <= neg_in[i];
            end
            s_reg     <= s_in;
            degen_reg <= degen_in;
        end
    end

    assign r_out     = r_reg;
    assign ks_out    = ks_reg;
    assign k_out     = k_reg;
    assign neg_out   = neg_reg;
    assign s_out     = s_reg;
    assign degen_out = degen_reg;
endmodule
`default_nettype wire

>>> hw/rtl/triangle_unit_normal_top.sv
// Top level of the triangle unit normal block: stream ports, sum of squares and cell chain.
// Instantiates tun_cross and tun_cell; depends on tun_pkg.
// The block takes one triangle per clock while no output word waits, and gives its unit
// normal, rounded to nearest and at most one in magnitude, after these registered steps:
// edges, products, cross product and squares, then the sum of squares, then one
// quotient bit in each cell of the chain of NORMAL_FRAC_BITS + 2 cells, and then the
// output register. The whole pipeline holds while an output word waits to be taken.
`default_nettype none
module triangle_unit_normal_top
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // point1_x, point1_y, point1_z, point2_x, ..., point3_z
    input  wire logic [((VERTEX_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [((LANES*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic      m_axis_tuser
);
    localparam int CW  = COORD_WIDTH;
    localparam int F   = NORMAL_FRAC_BITS;
    localparam int QW  = 4 * CW + 2;
    localparam int SW  = 4 * CW + 4;
    localparam int AW  = SW + 2 * F + 4;
    localparam int KW  = F + 2;
    localparam int NB  = F + 2;
    localparam int OW  = F + 2;
    localparam int PIPE = 5 + NB;
    localparam int ODW = ((LANES * OW + 7) / 8) * 8;

    logic                 en;
    logic signed [CW-1:0] pt [VERTEX_FIELDS];
    logic        [QW-1:0] sq [LANES];
    logic                 sq_neg [LANES];
    logic                 sq_degen;
    logic [PIPE-1:0]      vld_reg;
    logic [PIPE-1:0]      vld_next;
    logic                 out_vld_reg;
    logic [AW-1:0]        ch_r  [NB+1][LANES];
    logic [AW-1:0]        ch_ks [NB+1][LANES];
    logic [KW-1:0]        ch_k  [NB+1][LANES];
    logic                 ch_neg [NB+1][LANES];
    logic [AW-1:0]        ch_s  [NB+1];
    logic                 ch_degen [NB+1];
    logic [AW-1:0]        r0_reg [LANES];
    logic                 neg0_reg [LANES];
    logic [AW-1:0]        s0_reg;
    logic                 degen0_reg;
    logic [OW-1:0]        nrm_reg [LANES];
    logic                 degen_out_reg;
    logic [F:0]           mq [LANES];

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        for (int i = 0; i < VERTEX_FIELDS; i++)
        begin
            pt[i] = s_axis_tdata[i*CW +: CW];
        end
        vld_next = {vld_reg[PIPE-2:0], s_axis_tvalid};
    end

    tun_cross #(
        .CW (CW)
    ) u_cross (
        .clk   (clk),
        .en    (en),
        .pt    (pt),
        .sq    (sq),
        .neg   (sq_neg),
        .degen (sq_degen)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                r0_reg[i]   <= AW'(sq[i]) << (2 * F + 2);
                neg0_reg[i] <= sq_neg[i];
            end
            s0_reg     <= AW'(sq[0]) + AW'(sq[1]) + AW'(sq[2]);
            degen0_reg <= sq_degen;
        end
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ch_r[0][i]   = r0_reg[i];
            ch_ks[0][i]  = '0;
            ch_k[0][i]   = '0;
            ch_neg[0][i] = neg0_reg[i];
        end
        ch_s[0]     = s0_reg;
        ch_degen[0] = degen0_reg;
    end

    for (genvar g = 0; g < NB; g++)
    begin : g_cell
        tun_cell #(
            .AW (AW),
            .KW (KW),
            .J  (NB - 1 - g)
        ) u_cell (
            .clk       (clk),
            .en        (en),
            .r_in      (ch_r[g]),
            .ks_in     (ch_ks[g]),
            .k_in      (ch_k[g]),
            .neg_in    (ch_neg[g]),
            .s_in      (ch_s[g]),
            .degen_in  (ch_degen[g]),
            .r_out     (ch_r[g+1]),
            .ks_out    (ch_ks[g+1]),
            .k_out     (ch_k[g+1]),
            .neg_out   (ch_neg[g+1]),
            .s_out     (ch_s[g+1]),
            .degen_out (ch_degen[g+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mq[i] = (F+1)'(((KW+1)'(ch_k[NB][i]) + (KW+1)'(1)) >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (ch_degen[NB])
                begin
                    nrm_reg[i] <= '0;
                end
                else if (ch_neg[NB][i])
                begin
                    nrm_reg[i] <= -OW'(mq[i]);
                end
                else
                begin
                    nrm_reg[i] <= OW'(mq[i]);
                end
            end
            degen_out_reg <= ch_degen[NB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[PIPE-1];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = ODW'({nrm_reg[2], nrm_reg[1], nrm_reg[0]});
    assign m_axis_tuser  = degen_out_reg;
endmodule
`default_nettype wire

>>> hw/rtl/tun_checker.sv
// Port checker for the triangle unit normal block, bound to the top level.
// Sees only the top-level ports; depends on tun_pkg.
`default_nettype none
module tun_checker
    import tun_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    localparam logic signed [15:0] ONE = 16'sd16384;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate word carries a non-zero normal");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= ONE
            && $signed(m_axis_tdata[15:0]) >= -ONE
            && $signed(m_axis_tdata[31:16]) <= ONE
            && $signed(m_axis_tdata[31:16]) >= -ONE
            && $signed(m_axis_tdata[47:32]) <= ONE
            && $signed(m_axis_tdata[47:32]) >= -ONE)
        else $error("normal component beyond unit range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata != '0)
        else $error("non-degenerate word carries a zero normal");
endmodule

bind triangle_unit_normal_top tun_checker u_tun_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
